// ===== rtl/wra_pkg.sv =====
// Package for the windowed RMS amplitude block.
// Holds shared widths, the job record passed from front to back, and back-end states.
// No dependencies.
`default_nettype none
package wra_pkg;
  localparam int POS_W             = 32;
  localparam int WIN_W             = 6;
  localparam int DIV_W             = 7;
  localparam int RMS_W             = 16;
  localparam int RESET_HALF_WINDOW = 21;

  typedef struct packed {
    logic [POS_W-1:0] t_first;
    logic [POS_W-1:0] t_final;
    logic [POS_W-1:0] count;
    logic [WIN_W-1:0] w;
    logic             last;
  } wra_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WALK,
    B_DRAIN,
    B_DIV,
    B_SQRT,
    B_OUT
  } wra_bstate_t;
endpackage
`default_nettype wire

// ===== rtl/wra_front.sv =====
// Front end: accepts samples, writes the sample ring, tracks trace position,
// and issues output jobs. Depends on wra_pkg.
`default_nettype none
module wra_front #(
  parameter int MAX_HALF_WINDOW = 32,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int RA_W            = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0]  in_sample,
  input  wire logic                     in_last,
  input  wire logic                     cfg_we,
  input  wire logic [wra_pkg::WIN_W-1:0] cfg_data,
  input  wire logic                     busy,
  output logic                          push,
  output wra_pkg::wra_job_t             job,
  output logic [RA_W-1:0]               job_addr,
  output logic                          ring_we,
  output logic [RA_W-1:0]               ring_waddr,
  output logic [SAMPLE_WIDTH-1:0]       ring_wdata
);
  import wra_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;

  logic [WIN_W-1:0] hw_r, wlat_r, wlat_nxt, w_cur, hw_clamp;
  logic [POS_W-1:0] pos_r, pos_nxt, next_r, next_nxt;
  logic [RA_W-1:0]  wp_r, wp_nxt;
  logic             acc;

  assign in_ready  = !busy;
  assign acc       = in_valid && in_ready;
  assign hw_clamp  = (hw_r > WIN_W'(MAX_HALF_WINDOW)) ? WIN_W'(MAX_HALF_WINDOW) : hw_r;
  assign w_cur     = (pos_r == '0) ? hw_clamp : wlat_r;
  assign ring_we   = acc;
  assign ring_waddr = wp_r;
  assign ring_wdata = in_sample;
  assign job_addr  = wp_r;

  always_comb begin
    pos_nxt  = pos_r;
    next_nxt = next_r;
    wp_nxt   = wp_r;
    wlat_nxt = wlat_r;
    push     = 1'b0;
    job      = '0;
    job.w    = w_cur;
    job.count = pos_r + POS_W'(1);
    if (acc) begin
      wlat_nxt = w_cur;
      if (in_last) begin
        push        = 1'b1;
        job.t_first = next_r;
        job.t_final = pos_r;
        job.last    = 1'b1;
        pos_nxt     = '0;
        next_nxt    = '0;
        wp_nxt      = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        wp_nxt  = (wp_r == RA_W'(DEPTH - 1)) ? '0 : wp_r + RA_W'(1);
        if (pos_r >= POS_W'(w_cur)) begin
          push        = 1'b1;
          job.t_first = pos_r - POS_W'(w_cur);
          job.t_final = pos_r - POS_W'(w_cur);
          next_nxt    = pos_r - POS_W'(w_cur) + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= WIN_W'(RESET_HALF_WINDOW);
      wlat_r <= '0;
      pos_r  <= '0;
      next_r <= '0;
      wp_r   <= '0;
    end else begin
      if (cfg_we) hw_r <= cfg_data;
      wlat_r <= wlat_nxt;
      pos_r  <= pos_nxt;
      next_r <= next_nxt;
      wp_r   <= wp_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wra_fifo.sv =====
// Two-entry job queue between front and back ends.
// No dependencies.
`default_nettype none
module wra_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  logic [W-1:0] mem_r [2];
  logic         rp_r, wp_r;
  logic [1:0]   cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= 1'b0;
      wp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wra_back.sv =====
// Back end: sample ring, folded window walk with squaring accumulator,
// iterative divide by window size and integer square root. Depends on wra_pkg.
`default_nettype none
module wra_back #(
  parameter int MAX_HALF_WINDOW = 32,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int RA_W            = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    job_valid,
  input  wra_pkg::wra_job_t            job,
  input  wire logic [RA_W-1:0]         job_addr,
  output logic                         job_pop,
  input  wire logic                    ring_we,
  input  wire logic [RA_W-1:0]         ring_waddr,
  input  wire logic [SAMPLE_WIDTH-1:0] ring_wdata,
  output logic                         active,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [wra_pkg::RMS_W-1:0]    out_rms,
  output logic                         out_last
);
  import wra_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int SUM_W = 2 * SAMPLE_WIDTH + DIV_W;
  localparam int RT_W  = SUM_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  wra_bstate_t st_r, st_nxt;

  logic [SAMPLE_WIDTH-1:0] ring [DEPTH];
  logic [POS_W-1:0]  t_r, tend_r, n_r, p_r;
  logic [WIN_W-1:0]  w_r;
  logic              last_r, dir_r;
  logic [RA_W-1:0]   wl_r;
  logic [DIV_W-1:0]  k_r;
  logic [SUM_W-1:0]  acc_r, quo_r;
  logic [SAMPLE_WIDTH-1:0] rd_r;
  logic              v1_r, v2_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIV_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RT_W-1:0]   rv_r, res_r, bit_r;
  logic              out_valid_r, out_last_r;
  logic [RMS_W-1:0]  out_rms_r;

  logic              rd_en, walk_done, div_done, sqrt_done, load_out, t_done;
  logic [POS_W-1:0]  ring_age, base_p, step_p;
  logic              base_dir, step_dir;
  logic [RA_W:0]     diff;
  logic [RA_W-1:0]   raddr;
  logic [DIV_W-1:0]  dsor, rem_n;
  logic [DIV_W:0]    trial, tsub;
  logic              tge;
  logic [SUM_W-1:0]  quo_n;
  logic [RT_W-1:0]   rb, rv_n, res_n;
  logic              sge;

  assign active    = (st_r != B_IDLE);
  assign out_valid = out_valid_r;
  assign out_rms   = out_rms_r;
  assign out_last  = out_last_r;

  // ring address of folded position p_r, counted back from the newest sample
  assign ring_age = n_r - POS_W'(1) - p_r;
  assign diff  = {1'b0, wl_r} - {1'b0, ring_age[RA_W-1:0]};
  assign raddr = diff[RA_W] ? diff[RA_W-1:0] + RA_W'(DEPTH) : diff[RA_W-1:0];

  // edge-repeat walk: center, then w steps left, then w steps right
  always_comb begin
    base_p   = p_r;
    base_dir = dir_r;
    if (k_r == '0) begin
      base_p   = t_r;
      base_dir = 1'b0;
    end else if (k_r == DIV_W'(w_r)) begin
      base_p   = t_r;
      base_dir = 1'b1;
    end
    step_p   = base_p;
    step_dir = base_dir;
    if (!base_dir) begin
      if (base_p == '0) step_dir = 1'b1;
      else              step_p   = base_p - POS_W'(1);
    end else begin
      if (base_p == n_r - POS_W'(1)) step_dir = 1'b0;
      else                           step_p   = base_p + POS_W'(1);
    end
  end

  assign dsor  = {w_r, 1'b1};
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign tsub  = trial - {1'b0, dsor};
  assign tge   = (trial >= {1'b0, dsor});
  assign rem_n = tge ? tsub[DIV_W-1:0] : trial[DIV_W-1:0];
  assign quo_n = {quo_r[SUM_W-2:0], tge};

  assign rb    = res_r + bit_r;
  assign sge   = (rv_r >= rb);
  assign rv_n  = sge ? rv_r - rb : rv_r;
  assign res_n = sge ? (res_r >> 1) + bit_r : (res_r >> 1);

  assign walk_done = (k_r == {w_r, 1'b0});
  assign div_done  = (cnt_r == CNT_W'(SUM_W - 1));
  assign sqrt_done = bit_r[0];
  assign t_done    = (t_r == tend_r);

  always_comb begin
    st_nxt   = st_r;
    job_pop  = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          st_nxt  = B_WALK;
        end
      end
      B_WALK: begin
        rd_en = 1'b1;
        if (walk_done) st_nxt = B_DRAIN;
      end
      B_DRAIN: begin
        if (!v1_r && !v2_r) st_nxt = B_DIV;
      end
      B_DIV: begin
        if (div_done) st_nxt = B_SQRT;
      end
      B_SQRT: begin
        if (sqrt_done) st_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          st_nxt   = t_done ? B_IDLE : B_WALK;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_waddr] <= ring_wdata;
    if (rd_en)   rd_r <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    sq_r <= SQ_W'($signed(rd_r) * $signed(rd_r));
    if (job_pop) begin
      t_r    <= job.t_first;
      p_r    <= job.t_first;
      tend_r <= job.t_final;
      n_r    <= job.count;
      w_r    <= job.w;
      last_r <= job.last;
      wl_r   <= job_addr;
      k_r    <= '0;
      acc_r  <= '0;
    end else if (load_out && !t_done) begin
      t_r   <= t_r + POS_W'(1);
      p_r   <= t_r + POS_W'(1);
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (st_r == B_WALK) begin
        p_r   <= step_p;
        dir_r <= step_dir;
        k_r   <= k_r + DIV_W'(1);
      end
      if (v2_r) acc_r <= acc_r + SUM_W'(sq_r);
    end
    if (st_r == B_DRAIN) begin
      quo_r <= acc_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (st_r == B_DIV) begin
      quo_r <= quo_n;
      rem_r <= rem_n;
      cnt_r <= cnt_r + CNT_W'(1);
      if (div_done) begin
        rv_r  <= RT_W'(quo_n);
        res_r <= '0;
        bit_r <= RT_W'(1) << (RT_W - 2);
      end
    end
    if (st_r == B_SQRT) begin
      rv_r  <= rv_n;
      res_r <= res_n;
      bit_r <= bit_r >> 2;
    end
    if (load_out) begin
      out_rms_r  <= res_r[RMS_W-1:0];
      out_last_r <= last_r && t_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/windowed_rms_amplitude.sv =====
// Windowed RMS amplitude, top level: front end, job queue, back end.
// Depends on wra_pkg, wra_front, wra_fifo, wra_back.
//
// Usage: samples enter on in_* (tdata = sample, tlast = last sample of a trace).
// Results leave on out_* (tdata = rms, tlast = result for the final position).
// cfg_wr_en/cfg_wr_data set the half window w (clamped to MAX_HALF_WINDOW);
// it is latched at the first sample of each trace.
// Once sample t+w is in, result t is produced; the last sample releases all
// remaining results of the trace.
// Each result walks 2w+1 ring reads through the squaring pipeline (ring read,
// square, accumulate), then a bit-serial divide and a digit-serial root.
// The back end takes a job from the queue before its first result; a
// sample that releases no result does not hold off the input.
// in_tready is low while results of a job are still being computed; a
// finished result waits in the output register, and a stalled receiver
// holds back only the next result. Reset clears control state and sets the
// half window to 21; the ring needs no clearing.
`default_nettype none
module windowed_rms_amplitude #(
  parameter int MAX_HALF_WINDOW = 32,
  parameter int SAMPLE_WIDTH    = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [15:0]                              out_tdata,  // [15:0] rms
  output logic                                     out_tlast,
  input  wire logic                                cfg_wr_en,
  input  wire logic [wra_pkg::WIN_W-1:0]           cfg_wr_data
);
  import wra_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int RA_W  = $clog2(DEPTH);
  localparam int JW    = $bits(wra_job_t) + RA_W;

  logic                    push, pop, empty, busy, active;
  wra_job_t                fjob, bjob;
  logic [RA_W-1:0]         faddr, baddr;
  logic                    ring_we;
  logic [RA_W-1:0]         ring_waddr;
  logic [SAMPLE_WIDTH-1:0] ring_wdata;
  logic [JW-1:0]           qout;

  assign busy = !empty || active;
  assign bjob  = qout[JW-1:RA_W];
  assign baddr = qout[RA_W-1:0];

  wra_front #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH), .RA_W(RA_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sample(in_tdata[SAMPLE_WIDTH-1:0]), .in_last(in_tlast),
    .cfg_we(cfg_wr_en), .cfg_data(cfg_wr_data),
    .busy(busy), .push(push), .job(fjob), .job_addr(faddr),
    .ring_we(ring_we), .ring_waddr(ring_waddr), .ring_wdata(ring_wdata)
  );

  wra_fifo #(.W(JW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .din({fjob, faddr}),
    .pop(pop), .dout(qout), .empty(empty)
  );

  wra_back #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH), .RA_W(RA_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(!empty), .job(bjob), .job_addr(baddr), .job_pop(pop),
    .ring_we(ring_we), .ring_waddr(ring_waddr), .ring_wdata(ring_wdata),
    .active(active),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_rms(out_tdata), .out_last(out_tlast)
  );
endmodule
`default_nettype wire

// ===== rtl/wra_checker.sv =====
// Port-level checks for windowed_rms_amplitude, bound to the top level.
// Depends on windowed_rms_amplitude.
`default_nettype none
module wra_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input not held off after last transfer");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[14:0] == 15'd0)
    else $error("rms above full scale");
endmodule

bind windowed_rms_amplitude wra_checker u_wra_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tlast(in_tlast),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for windowed_rms_amplitude: random and directed traces, folded-window RMS predictor.
// Driver and monitor are clocked always blocks fed by queues; depends on wra_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  import wra_pkg::*;

  localparam int MAXW = 32;
  localparam int WD_LIMIT = 20000;
  localparam int HOLD_CYC = 400;
  localparam int N_ITEMS = 430;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } smp_t;
  typedef struct packed {
    logic [15:0] rms;
    logic        last;
  } rms_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0, cfg_wr_en = 0;
  logic [15:0] in_tdata = 0;
  logic [WIN_W-1:0] cfg_wr_data = 0;
  logic in_tready, out_tvalid, out_tlast;
  logic [15:0] out_tdata;

  windowed_rms_amplitude u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  smp_t pending_q[$];
  rms_t rms_q[$];
  int errors = 0;
  bit no_idle = 0;
  int hold_off = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int idle_cnt = 0;

  // predictor state
  logic [5:0] cur_hw = 6'(RESET_HALF_WINDOW);
  int lat_w;
  logic signed [15:0] trace[$];
  int next_out = 0;

  function automatic int fold_pos(int i, int n);
    int p, m;
    p = 2 * n;
    m = i % p;
    if (m < 0) m += p;
    if (m >= n) m = p - 1 - m;
    return m;
  endfunction

  function automatic logic [15:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[15:0];
  endfunction

  function automatic logic [15:0] window_rms(int t, int n);
    logic [63:0] s, sq;
    int mag;
    s = 0;
    for (int k = -lat_w; k <= lat_w; k++) begin
      mag = trace[fold_pos(t + k, n)];
      if (mag < 0) mag = -mag;
      sq = 64'(mag * mag);
      s += sq;
    end
    return root_floor(s / 64'(2 * lat_w + 1));
  endfunction

  task automatic predict_rms(smp_t it);
    int n;
    rms_t r;
    if (trace.size() == 0) begin
      lat_w = (cur_hw > MAXW) ? MAXW : int'(cur_hw);
      next_out = 0;
    end
    trace = {trace, it.sample};
    n = trace.size();
    if (!it.last) begin
      if (n - 1 >= lat_w) begin
        r.rms = window_rms(n - 1 - lat_w, n);
        r.last = 1'b0;
        rms_q = {rms_q, r};
        next_out = n - lat_w;
      end
    end else begin
      while (next_out < n) begin
        r.rms = window_rms(next_out, n);
        r.last = (next_out == n - 1);
        rms_q = {rms_q, r};
        next_out++;
      end
      trace.delete();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_rms('{in_tdata, in_tlast});
        void'(pending_q.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 30)) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_q[0].sample;
          in_tlast <= pending_q[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HOLD_CYC;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (rms_q.size() == 0) begin
          $error("unexpected result rms=%0d last=%0b", out_tdata, out_tlast);
          errors++;
        end else begin
          if (out_tdata !== rms_q[0].rms) begin
            $error("rms expected %0d actual %0d", rms_q[0].rms, out_tdata);
            errors++;
          end
          if (out_tlast !== rms_q[0].last) begin
            $error("last_result expected %0b actual %0b", rms_q[0].last, out_tlast);
            errors++;
          end
          void'(rms_q.pop_front());
        end
      end
      if (hold_off > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || $urandom_range(99) >= 30;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_trace(int len, int mode);
    smp_t it;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.sample = 16'($urandom);
        1: it.sample = 16'h8000;
        2: it.sample = 16'h7fff;
        3: it.sample = 16'h0000;
        default: it.sample = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
      endcase
      it.last = (i == len - 1);
      pending_q = {pending_q, it};
    end
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || in_tvalid || rms_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_hw(logic [5:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cur_hw <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int total;
    smp_t it;
    bit pressed;
    pressed = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed: reset window, extremes, single-sample and short traces
    add_trace(3, 1);
    add_trace(1, 2);
    wait_drain();
    set_hw(6'd0);
    add_trace(4, 1);
    add_trace(1, 0);
    wait_drain();
    set_hw(6'd63);
    add_trace(2, 2);
    wait_drain();
    set_hw(6'd32);
    add_trace(5, 3);
    // write mid-trace: takes effect with the next trace
    it.sample = 16'h1234;
    it.last = 1'b0;
    pending_q = {pending_q, it};
    wait_drain();
    set_hw(6'd1);
    add_trace(2, 0);
    wait_drain();
    total = 0;
    while (total < N_ITEMS) begin
      int len, w;
      w = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(4);
      set_hw(6'(w));
      for (int k = 0; k < 4 && total < N_ITEMS; k++) begin
        len = $urandom_range(4) == 0 ? $urandom_range(80, 40) : $urandom_range(1, 12);
        if (len > N_ITEMS - total) len = N_ITEMS - total;
        add_trace(len, $urandom_range(5) == 0 ? $urandom_range(1, 3) : 4 * $urandom_range(1));
        total += len;
      end
      if (!pressed && total >= 150) begin
        pressed = 1;
        no_idle = 1;
        hold_req++;
      end else begin
        no_idle = 0;
      end
      wait_drain();
    end
    wait_drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
